### src/moving_average_crossover_signal_defines.svh
// Assertion macros for the moving average crossover block checkers.
`ifndef MOVING_AVERAGE_CROSSOVER_SIGNAL_DEFINES_SVH
`define MOVING_AVERAGE_CROSSOVER_SIGNAL_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define MACS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define MACS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mac_pkg.sv
// Shared types and constants for the moving average crossover block.
`default_nettype none
package mac_pkg;

   // Fixed widths of the register file and ports
   localparam int WIN_BITS       = 9;
   localparam int CSR_INDEX_BITS = 2;

   // Parameter defaults
   localparam int DEF_MAX_WINDOW = 256;
   localparam int DEF_PRICE_BITS = 32;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_WINDOW  = 2'd1;

   // Register reset values
   localparam logic [WIN_BITS-1:0] SHORT_WINDOW_RESET = 9'd10;
   localparam logic [WIN_BITS-1:0] LONG_WINDOW_RESET  = 9'd30;

   // Signal codes
   localparam logic signed [1:0] SIG_NONE = 2'sb00;
   localparam logic signed [1:0] SIG_BUY  = 2'sb01;
   localparam logic signed [1:0] SIG_SELL = 2'sb11;

   // Relation of short average to long average
   typedef enum logic [1:0] {
      REL_LESS,
      REL_EQUAL,
      REL_GREATER
   } rel_type;

   // Per-cell control of the delay line
   typedef struct packed {
      logic shift;
      logic insert;
   } cell_ctl_type;

endpackage
`default_nettype wire

### src/mac_cell.sv
// One price cell of a programmable-length delay line.
`default_nettype none
module mac_cell import mac_pkg::*; #(
   parameter int PRICE_BITS = DEF_PRICE_BITS
) (
   input  wire logic                  clock,
   input  wire cell_ctl_type          ctl,
   input  wire logic [PRICE_BITS-1:0] new_price,
   input  wire logic [PRICE_BITS-1:0] prev_price,
   output logic      [PRICE_BITS-1:0] price
);

   logic [PRICE_BITS-1:0] price_ff;
   logic [PRICE_BITS-1:0] price_in;

   // Take the new price at the entry cell, else the neighbor's price
   always_comb begin
      price_in = ctl.insert ? new_price : prev_price;
   end

   // Advance on every accepted bar with a valid window pair
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         price_ff <= price_in;
      end
   end

   assign price = price_ff;

endmodule
`default_nettype wire

### src/mac_delay_line.sv
// Row of price cells: the tail shows the price entered `length` bars ago.
`default_nettype none
module mac_delay_line import mac_pkg::*; #(
   parameter int DEPTH      = DEF_MAX_WINDOW,
   parameter int PRICE_BITS = DEF_PRICE_BITS,
   parameter int LEN_BITS   = WIN_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  shift,
   input  wire logic [LEN_BITS-1:0]   length,
   input  wire logic [PRICE_BITS-1:0] din,
   output logic      [PRICE_BITS-1:0] dout
);

   logic [LEN_BITS-1:0]   entry;
   logic [PRICE_BITS-1:0] tap [DEPTH];

   // Entry cell sits `length` cells before the tail
   assign entry = LEN_BITS'(DEPTH) - length;

   for (genvar j = 0; j < DEPTH; j++) begin : g_cell
      cell_ctl_type ctl;
      assign ctl.shift  = shift;
      assign ctl.insert = (entry == LEN_BITS'(j));
      if (j == 0) begin : g_head
         mac_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .new_price (din),
            .prev_price(din),
            .price     (tap[j])
         );
      end else begin : g_body
         mac_cell #(.PRICE_BITS(PRICE_BITS)) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .new_price (din),
            .prev_price(tap[j-1]),
            .price     (tap[j])
         );
      end
   end

   assign dout = tap[DEPTH-1];

endmodule
`default_nettype wire

### src/moving_average_crossover_signal.sv
// Top level: moving average crossover signal generator.
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  request | req_valid req_ready req_price req_restart | in
//  result  | rsp_valid rsp_ready rsp_signal          | out
//  config  | csr_valid csr_ready csr_index csr_data  | in
//
// One request per cycle while no stall holds the pipeline; its result
// goes through sum update, window products, compare and signal register.
// The running sums and the two delay lines update in the accept cycle, so
// back-to-back bars chain through single add/subtract paths.
// A stalled result holds its stage; earlier stages keep filling until the
// three-stage pipeline is full. Reset is synchronous; no clearing pass.
`default_nettype none
module moving_average_crossover_signal import mac_pkg::*; #(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PRICE_BITS = DEF_PRICE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [PRICE_BITS-1:0]     req_price,
   input  wire logic                      req_restart,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [1:0]              rsp_signal,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [WIN_BITS-1:0]       csr_data
);

   localparam int CntBits  = $clog2(MAX_WINDOW + 2);
   localparam int CmpBits  = (CntBits > WIN_BITS) ? CntBits : WIN_BITS;
   localparam int SumBits  = PRICE_BITS + $clog2(MAX_WINDOW);
   localparam int ProdBits = SumBits + WIN_BITS;

   // Configuration and series state
   logic [WIN_BITS-1:0] short_window_ff, long_window_ff;
   logic [CntBits-1:0]  bars_seen_ff, bars_seen_in;
   logic [SumBits-1:0]  short_sum_ff, short_sum_in;
   logic [SumBits-1:0]  long_sum_ff, long_sum_in;
   rel_type             prev_rel_ff, prev_rel_in;

   // Pipeline stages
   logic                s1_valid_ff, s1_cmp_ff, s1_sig_ff, s1_restart_ff;
   logic                s2_valid_ff, s2_cmp_ff, s2_sig_ff, s2_restart_ff;
   logic [ProdBits-1:0] s2_short_prod_ff, s2_long_prod_ff;
   logic                rsp_valid_ff;
   logic signed [1:0]   rsp_signal_ff, rsp_signal_in;

   logic                go1, go2, go3, accept, csr_write, clear_cfg;
   logic                win_ok, shift;
   logic [CmpBits-1:0]  s_ext, l_ext, n_ext;
   logic [CntBits-1:0]  n;
   logic [SumBits-1:0]  short_base, long_base;
   logic [PRICE_BITS-1:0] short_old, long_old;
   logic                cmp_en, sig_en;
   rel_type             prev_rel, rel;

   // Stall only where the next stage is full and not moving
   assign go3       = !rsp_valid_ff || rsp_ready;
   assign go2       = !s2_valid_ff || go3;
   assign go1       = !s1_valid_ff || go2;
   assign req_ready = go1;
   assign accept    = req_valid && go1;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;
   assign clear_cfg = csr_write &&
                      (csr_index == CSR_SHORT_WINDOW || csr_index == CSR_LONG_WINDOW);

   // Check the window pair
   assign s_ext  = CmpBits'(short_window_ff);
   assign l_ext  = CmpBits'(long_window_ff);
   assign win_ok = (s_ext != '0) && (l_ext != '0) && (s_ext < l_ext) &&
                   (l_ext <= CmpBits'(MAX_WINDOW));

   // Restart drops the history before this bar is counted
   assign n          = req_restart ? '0 : bars_seen_ff;
   assign n_ext      = CmpBits'(n);
   assign short_base = req_restart ? '0 : short_sum_ff;
   assign long_base  = req_restart ? '0 : long_sum_ff;
   assign shift      = accept && win_ok;
   assign cmp_en     = win_ok && (n_ext >= l_ext - CmpBits'(1));
   assign sig_en     = win_ok && (n_ext >= l_ext);

   // Delay lines give the price leaving each window
   mac_delay_line #(
      .DEPTH     (MAX_WINDOW),
      .PRICE_BITS(PRICE_BITS),
      .LEN_BITS  (CmpBits)
   ) u_short_line (
      .clock (clock),
      .shift (shift),
      .length(s_ext),
      .din   (req_price),
      .dout  (short_old)
   );

   mac_delay_line #(
      .DEPTH     (MAX_WINDOW),
      .PRICE_BITS(PRICE_BITS),
      .LEN_BITS  (CmpBits)
   ) u_long_line (
      .clock (clock),
      .shift (shift),
      .length(l_ext),
      .din   (req_price),
      .dout  (long_old)
   );

   // Update running sums and bar count; a window register write clears them
   always_comb begin
      bars_seen_in = bars_seen_ff;
      short_sum_in = short_sum_ff;
      long_sum_in  = long_sum_ff;
      if (clear_cfg) begin
         bars_seen_in = '0;
         short_sum_in = '0;
         long_sum_in  = '0;
      end else if (accept) begin
         bars_seen_in = n;
         short_sum_in = short_base;
         long_sum_in  = long_base;
         if (win_ok) begin
            short_sum_in = SumBits'(({1'b0, short_base} + (SumBits + 1)'(req_price)) -
                           ((n_ext >= s_ext) ? (SumBits + 1)'(short_old) : '0));
            long_sum_in  = SumBits'(({1'b0, long_base} + (SumBits + 1)'(req_price)) -
                           ((n_ext >= l_ext) ? (SumBits + 1)'(long_old) : '0));
            if (n_ext < CmpBits'(MAX_WINDOW + 1)) begin
               bars_seen_in = CntBits'(n + CntBits'(1));
            end
         end
      end
   end

   // Compare the cross products and form the signal
   always_comb begin
      prev_rel      = s2_restart_ff ? REL_EQUAL : prev_rel_ff;
      rsp_signal_in = SIG_NONE;
      if (s2_short_prod_ff > s2_long_prod_ff) begin
         rel = REL_GREATER;
      end else if (s2_short_prod_ff == s2_long_prod_ff) begin
         rel = REL_EQUAL;
      end else begin
         rel = REL_LESS;
      end
      prev_rel_in = prev_rel;
      if (s2_cmp_ff) begin
         prev_rel_in = rel;
         if (s2_sig_ff) begin
            if (prev_rel != REL_GREATER && rel == REL_GREATER) begin
               rsp_signal_in = SIG_BUY;
            end else if (prev_rel != REL_LESS && rel == REL_LESS) begin
               rsp_signal_in = SIG_SELL;
            end
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         short_window_ff <= SHORT_WINDOW_RESET;
         long_window_ff  <= LONG_WINDOW_RESET;
         bars_seen_ff    <= '0;
         short_sum_ff    <= '0;
         long_sum_ff     <= '0;
         prev_rel_ff     <= REL_EQUAL;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         bars_seen_ff <= bars_seen_in;
         short_sum_ff <= short_sum_in;
         long_sum_ff  <= long_sum_in;
         if (csr_write && csr_index == CSR_SHORT_WINDOW) begin
            short_window_ff <= csr_data;
         end
         if (csr_write && csr_index == CSR_LONG_WINDOW) begin
            long_window_ff <= csr_data;
         end
         if (go1) begin
            s1_valid_ff <= accept;
         end
         if (go2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (go3) begin
            rsp_valid_ff <= s2_valid_ff;
         end
         if (clear_cfg) begin
            prev_rel_ff <= REL_EQUAL;
         end else if (go3 && s2_valid_ff) begin
            prev_rel_ff <= prev_rel_in;
         end
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmp_ff     <= cmp_en;
         s1_sig_ff     <= sig_en;
         s1_restart_ff <= req_restart;
      end
      if (go2 && s1_valid_ff) begin
         s2_cmp_ff        <= s1_cmp_ff;
         s2_sig_ff        <= s1_sig_ff;
         s2_restart_ff    <= s1_restart_ff;
         s2_short_prod_ff <= ProdBits'(short_sum_ff) * ProdBits'(long_window_ff);
         s2_long_prod_ff  <= ProdBits'(long_sum_ff) * ProdBits'(short_window_ff);
      end
      if (go3 && s2_valid_ff) begin
         rsp_signal_ff <= rsp_signal_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_signal = rsp_signal_ff;

endmodule
`default_nettype wire

### src/mac_checker.sv
// Port-level checker for the moving average crossover block, bound to the top.
`include "moving_average_crossover_signal_defines.svh"
`default_nettype none
module mac_checker import mac_pkg::*; (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic signed [1:0]         rsp_signal,
   input wire logic                      csr_valid,
   input wire logic                      csr_ready,
   input wire logic [CSR_INDEX_BITS-1:0] csr_index
);

   logic [2:0]        pending_ff;
   logic signed [1:0] last_sig_ff;
   logic              fresh_ff;
   logic              req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Track requests in flight, the last delivered signal and a fresh series
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= '0;
         last_sig_ff <= SIG_NONE;
         fresh_ff    <= 1'b1;
      end else begin
         pending_ff <= pending_ff + 3'(req_take) - 3'(rsp_take);
         if (rsp_take) begin
            last_sig_ff <= rsp_signal;
            fresh_ff    <= 1'b0;
         end
         // Only writes to a window register start a new series
         if (csr_valid && csr_ready &&
             (csr_index == CSR_SHORT_WINDOW || csr_index == CSR_LONG_WINDOW)) begin
            fresh_ff <= 1'b1;
         end
      end
   end

   `MACS_ASSERT_NOW(a_sig_code, rsp_valid, rsp_signal != 2'sb10, "invalid signal code")
   `MACS_ASSERT_NOW(a_no_extra, rsp_valid, pending_ff != 3'd0, "result without request")
   `MACS_ASSERT_NOW(a_alternate, rsp_take && rsp_signal != SIG_NONE,
      rsp_signal != last_sig_ff, "same crossover on consecutive results")
   `MACS_ASSERT_NOW(a_fresh_quiet, rsp_valid && fresh_ff, rsp_signal == SIG_NONE,
      "signal on first bar of a series")
   `MACS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_signal), "stalled result changed")

endmodule

bind moving_average_crossover_signal mac_checker u_mac_checker (.*);
`default_nettype wire
